/* src/flha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_pkg
// Shared types and constants for the free list handle allocator.
// ----------------------------------------------------------------------------
package flha_pkg;

  localparam int MaxHandles = 64;
  localparam int HandleW    = $clog2(MaxHandles + 1);
  localparam int IdxW       = $clog2(MaxHandles);
  localparam int OpW        = 2;
  localparam int StatusW    = 2;

  typedef logic [HandleW-1:0] handle_t;
  typedef logic [IdxW-1:0]    idx_t;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic    wr_en;
    idx_t    wr_addr;
    handle_t wr_data;
    handle_t free_head;
    handle_t used_count;
    handle_t handle;
    status_e status;
  } upd_t;

endpackage

/* src/free_list_handle_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_handle_allocator_unit
// Handle table with an embedded free list: allocate, free and lookup.
// ----------------------------------------------------------------------------
// result: registered after the update, which waits while the last result
//   is unaccepted; a new transaction is accepted only once the last has
//   updated, as the synchronous read of the link table precedes each update
// reset: used count and free list head cleared, no result pending; the link
//   table has no reset and no clearing pass, entries are written before use
module free_list_handle_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [flha_pkg::OpW-1:0]     operation_i,
  input  flha_pkg::handle_t            handle_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output flha_pkg::handle_t            handle_out_o,
  output logic [flha_pkg::StatusW-1:0] status_o
);
  import flha_pkg::*;

  logic             busy_q;
  logic [OpW-1:0]   op_q;
  handle_t          hin_q;
  handle_t          used_count_q;
  handle_t          free_head_q;
  logic             out_valid_q;
  handle_t          handle_out_q;
  logic [StatusW-1:0] status_q;

  logic    in_fire;
  logic    upd_fire;
  idx_t    rd_addr;
  handle_t link;
  upd_t    upd;

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign upd_fire   = busy_q && (!out_valid_q || out_ready_i);

  assign rd_addr = (op_e'(operation_i) == OP_ALLOC) ? IdxW'(free_head_q - HandleW'(1))
                                                    : IdxW'(handle_in_i - HandleW'(1));

  flha_link_ram #(
    .Depth (MaxHandles),
    .Width (HandleW)
  ) u_link_ram (
    .clk_i     (clk_i),
    .wr_en_i   (upd_fire && upd.wr_en),
    .wr_addr_i (upd.wr_addr),
    .wr_data_i (upd.wr_data),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (link)
  );

  flha_update u_update (
    .op_i         (op_q),
    .handle_i     (hin_q),
    .link_i       (link),
    .free_head_i  (free_head_q),
    .used_count_i (used_count_q),
    .upd_o        (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      used_count_q <= '0;
      free_head_q  <= '0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (upd_fire) begin
        busy_q <= 1'b0;
      end
      if (upd_fire) begin
        out_valid_q  <= 1'b1;
        used_count_q <= upd.used_count;
        free_head_q  <= upd.free_head;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= operation_i;
      hin_q <= handle_in_i;
    end
    if (upd_fire) begin
      handle_out_q <= upd.handle;
      status_q     <= upd.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign handle_out_o = handle_out_q;
  assign status_o     = status_q;

  a_used_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_count_q <= HandleW'(MaxHandles))
    else $error("used count beyond table size");

  a_head_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= used_count_q)
    else $error("free list head beyond used region");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q)
    else $error("accepted transaction not in flight");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OK) |-> (handle_out_q == '0))
    else $error("failed transaction returned a handle");

endmodule

/* src/flha_link_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_link_ram
// Single write, single read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module flha_link_ram #(
  parameter int Depth = 64,
  parameter int Width = 7
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/flha_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flha_update
// Decides the result and the table and list updates for one transaction.
// ----------------------------------------------------------------------------
module flha_update (
  input  logic [flha_pkg::OpW-1:0] op_i,
  input  flha_pkg::handle_t        handle_i,
  input  flha_pkg::handle_t        link_i,
  input  flha_pkg::handle_t        free_head_i,
  input  flha_pkg::handle_t        used_count_i,
  output flha_pkg::upd_t           upd_o
);
  import flha_pkg::*;

  logic    head_ok;
  logic    room_ok;
  logic    hdl_valid;
  handle_t used_inc;

  assign head_ok   = (free_head_i != '0) && (free_head_i <= used_count_i);
  assign room_ok   = used_count_i < HandleW'(MaxHandles);
  assign hdl_valid = (handle_i != '0) && (handle_i <= used_count_i) && (link_i == handle_i);
  assign used_inc  = used_count_i + HandleW'(1);

  always_comb begin
    upd_o            = '0;
    upd_o.free_head  = free_head_i;
    upd_o.used_count = used_count_i;
    upd_o.status     = ST_INVALID;
    case (op_e'(op_i))
      OP_ALLOC: begin
        if (head_ok) begin
          upd_o.wr_en     = 1'b1;
          upd_o.wr_addr   = IdxW'(free_head_i - HandleW'(1));
          upd_o.wr_data   = free_head_i;
          upd_o.free_head = link_i;
          upd_o.handle    = free_head_i;
          upd_o.status    = ST_OK;
        end else if (room_ok) begin
          upd_o.wr_en      = 1'b1;
          upd_o.wr_addr    = IdxW'(used_count_i);
          upd_o.wr_data    = used_inc;
          upd_o.used_count = used_inc;
          upd_o.free_head  = '0;
          upd_o.handle     = used_inc;
          upd_o.status     = ST_OK;
        end else begin
          upd_o.status = ST_FULL;
        end
      end
      OP_FREE: begin
        if (hdl_valid) begin
          upd_o.wr_en     = 1'b1;
          upd_o.wr_addr   = IdxW'(handle_i - HandleW'(1));
          upd_o.wr_data   = free_head_i;
          upd_o.free_head = handle_i;
          upd_o.handle    = handle_i;
          upd_o.status    = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (hdl_valid) begin
          upd_o.handle = handle_i;
          upd_o.status = ST_OK;
        end
      end
      default: begin
        upd_o.status = ST_INVALID;
      end
    endcase
  end

endmodule

/* bench/handle_alloc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_alloc_checker
// Watches both channels of the handle allocator, keeps its own copy of the
// link table, used count and free list head, works out the reply to every
// accepted request and compares each accepted reply with the oldest one due.
// ----------------------------------------------------------------------------
module handle_alloc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [flha_pkg::OpW-1:0]      operation_i,
  input  flha_pkg::handle_t             handle_in_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  flha_pkg::handle_t             handle_out_i,
  input  logic [flha_pkg::StatusW-1:0]  status_i,
  output int                            mismatch_count_o,
  output int                            replies_due_o
);
  import flha_pkg::*;

  typedef struct packed {
    handle_t handle;
    status_e status;
  } reply_t;

  handle_t link_words [MaxHandles];
  handle_t used_count;
  handle_t free_head;
  reply_t  due_replies [$];
  reply_t  oldest_due;
  int      mismatches = 0;

  function automatic bit handle_is_live(handle_t h);
    if (h == '0 || h > used_count) return 1'b0;
    return link_words[h - 1] == h;
  endfunction

  function automatic reply_t apply_request(logic [OpW-1:0] op, handle_t h);
    reply_t r;
    r.handle = '0;
    r.status = ST_INVALID;
    case (op)
      OP_ALLOC: begin
        if (free_head != '0 && free_head <= used_count) begin
          r.handle = free_head;
          free_head = link_words[r.handle - 1];
          link_words[r.handle - 1] = r.handle;
          r.status = ST_OK;
        end else if (used_count < MaxHandles) begin
          used_count = used_count + 1'b1;
          link_words[used_count - 1] = used_count;
          free_head = '0;
          r.handle = used_count;
          r.status = ST_OK;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_FREE: begin
        if (handle_is_live(h)) begin
          link_words[h - 1] = free_head;
          free_head = h;
          r.handle = h;
          r.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (handle_is_live(h)) begin
          r.handle = h;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_count = '0;
      free_head = '0;
      due_replies.delete();
      replies_due_o <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_replies.size() == 0) begin
          mismatches++;
          $display("%0t: reply with none due: handle %0d status %0d",
                   $time, handle_out_i, status_i);
        end else begin
          oldest_due = due_replies.pop_front();
          if (handle_out_i !== oldest_due.handle) begin
            mismatches++;
            $display("%0t: handle mismatch: expected %0d actual %0d",
                     $time, oldest_due.handle, handle_out_i);
          end
          if (status_i !== oldest_due.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, oldest_due.status, status_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_replies.push_back(apply_request(operation_i, handle_in_i));
      end
      replies_due_o <= due_replies.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

/* bench/tb_free_list_handle_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_list_handle_allocator_unit
// Drives allocate, free, lookup and unused requests into the handle allocator
// under several idle and stall mixes, with a long receiver hold-off, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_free_list_handle_allocator_unit;
  import flha_pkg::*;

  localparam int                CycleLimit = 200000;
  localparam int                PhaseItems = 335;
  localparam int                HoldCycles = 400;
  localparam logic [OpW-1:0]    OpUnused   = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic [OpW-1:0]      operation_i = '0;
  handle_t             handle_in_i = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  handle_t             handle_out_o;
  logic [StatusW-1:0]  status_o;

  int mismatch_count;
  int replies_due;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int cycle_count    = 0;

  free_list_handle_allocator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .handle_in_i  (handle_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .handle_out_o (handle_out_o),
    .status_o     (status_o)
  );

  handle_alloc_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .operation_i      (operation_i),
    .handle_in_i      (handle_in_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .handle_out_i     (handle_out_o),
    .status_i         (status_o),
    .mismatch_count_o (mismatch_count),
    .replies_due_o    (replies_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_free_list_handle_allocator_unit: done, errors");
      $finish;
    end
  end

  // receiver side, long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic offer(input logic [OpW-1:0] op, input handle_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    handle_in_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic random_requests(input int n);
    int             alloc_pct;
    int             pick;
    int             hsel;
    logic [OpW-1:0] op;
    handle_t        h;
    alloc_pct = 90;
    for (int i = 0; i < n; i++) begin
      // alternate fill, churn and drain stretches
      case ((i / 100) % 3)
        0:       alloc_pct = 90;
        1:       alloc_pct = 40;
        default: alloc_pct = 10;
      endcase
      pick = $urandom_range(99);
      if (pick < alloc_pct) begin
        op = OP_ALLOC;
      end else begin
        pick = $urandom_range(99);
        if (pick < 3) op = OpUnused;
        else if (pick < 65) op = OP_FREE;
        else op = OP_LOOKUP;
      end
      hsel = $urandom_range(19);
      if (hsel == 0) h = '0;
      else if (hsel == 1) h = handle_t'(MaxHandles);
      else h = handle_t'($urandom_range(MaxHandles, 1));
      offer(op, h);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: none handle, out of range, unused code, pop and extend
    offer(OP_LOOKUP, '0);
    offer(OP_FREE, '0);
    offer(OP_LOOKUP, handle_t'(MaxHandles));
    offer(OP_FREE, handle_t'(MaxHandles));
    offer(OpUnused, handle_t'(MaxHandles));
    offer(OP_ALLOC, handle_t'(MaxHandles));
    offer(OP_ALLOC, '0);
    offer(OP_ALLOC, '0);
    offer(OP_LOOKUP, handle_t'(2));
    offer(OP_FREE, handle_t'(2));
    offer(OP_FREE, handle_t'(2));
    offer(OP_LOOKUP, handle_t'(2));
    offer(OP_ALLOC, '0);
    offer(OP_FREE, handle_t'(1));
    offer(OP_FREE, handle_t'(3));
    offer(OP_ALLOC, '0);
    offer(OP_ALLOC, '0);
    offer(OP_ALLOC, '0);
    offer(OP_LOOKUP, handle_t'(4));
    offer(OP_LOOKUP, handle_t'(5));
    offer(OpUnused, '0);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    random_requests(PhaseItems);

    send_idle_pct = 50;
    recv_stall_pct = 0;
    random_requests(PhaseItems);

    send_idle_pct = 0;
    recv_stall_pct = 50;
    random_requests(PhaseItems);

    send_idle_pct = 17;
    recv_stall_pct = 17;
    random_requests(PhaseItems);

    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk_i);
    while (replies_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_free_list_handle_allocator_unit: done, clean");
    end else begin
      $display("tb_free_list_handle_allocator_unit: done, errors");
    end
    $finish;
  end

endmodule
